// File: hw/rtl/lpg_pkg.sv
package lpg_pkg;

	// Coordinate width of the position, target and distance state.
	localparam int COORD_BITS = 16;
	localparam int FIELD_W    = 16;
	localparam int SCREEN_W   = 15;
	localparam int LBYTES_W   = 18;
	localparam int BPP_W      = 6;
	localparam int OFS_W      = 33;
	localparam int CFG_DATA_W = 18;
	localparam int CFG_IDX_W  = 2;
	localparam int CMP_W      = (COORD_BITS > SCREEN_W) ? COORD_BITS : SCREEN_W;
	localparam int COL_OFS_W  = SCREEN_W + 3;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [COORD_BITS:0]   dcoord_t;
	typedef logic        [COORD_BITS-1:0] dist_t;
	typedef logic signed [COORD_BITS+1:0] err_t;
	typedef logic signed [COORD_BITS+2:0] err2_t;

	typedef enum logic {
		REQ_LOAD  = 1'b0,
		REQ_PIXEL = 1'b1
	} req_type_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SCREEN_WIDTH   = 2'd0,
		CFG_SCREEN_HEIGHT  = 2'd1,
		CFG_LINE_BYTES     = 2'd2,
		CFG_BITS_PER_PIXEL = 2'd3
	} cfg_reg_t;

	localparam logic [SCREEN_W-1:0] RST_SCREEN_WIDTH   = 15'd1920;
	localparam logic [SCREEN_W-1:0] RST_SCREEN_HEIGHT  = 15'd1080;
	localparam logic [LBYTES_W-1:0] RST_LINE_BYTES     = 18'd7680;
	localparam logic [BPP_W-1:0]    RST_BITS_PER_PIXEL = 6'd32;

	// Line endpoints as taken from the input channel.
	typedef struct packed {
		req_type_t              kind;
		logic [FIELD_W-1:0]     start_x;
		logic [FIELD_W-1:0]     start_y;
		logic [FIELD_W-1:0]     end_x;
		logic [FIELD_W-1:0]     end_y;
	} req_t;

	// One rasterized pixel before the framebuffer address is formed.
	typedef struct packed {
		coord_t x;
		coord_t y;
		logic   last;
	} pix_t;

	// Stepper status toward the top level.
	typedef struct packed {
		logic emit;
		logic active;
	} step_stat_t;

endpackage

// File: hw/rtl/lpg_stepper.sv
module lpg_stepper import lpg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  req_t       req,
	output step_stat_t stat,
	output pix_t       pix
);

	coord_t    cur_x_q, cur_y_q, target_x_q, target_y_q;
	dist_t     dist_x_q, dist_y_q;
	logic      step_x_neg_q, step_y_neg_q;
	err_t      err_q;
	logic      active_q;

	coord_t    sx, sy, ex, ey;
	dcoord_t   dx_raw, dy_raw;
	dist_t     ld_dx, ld_dy;
	err2_t     e2, dxw, dyw, err_sum;
	logic      move_x, move_y;
	coord_t    nx, ny;
	logic      done;
	logic      emit;

	// Load path: wrap the fields to the coordinate width, form distances.
	always_comb begin
		sx = coord_t'($signed(req.start_x));
		sy = coord_t'($signed(req.start_y));
		ex = coord_t'($signed(req.end_x));
		ey = coord_t'($signed(req.end_y));
		dx_raw = dcoord_t'(ex) - dcoord_t'(sx);
		dy_raw = dcoord_t'(ey) - dcoord_t'(sy);
		ld_dx = dx_raw[COORD_BITS] ? dist_t'(-dx_raw) : dist_t'(dx_raw);
		ld_dy = dy_raw[COORD_BITS] ? dist_t'(-dy_raw) : dist_t'(dy_raw);
	end

	// Step path: both tests use the doubled error from before the step.
	always_comb begin
		e2 = err2_t'(err_q) <<< 1;
		dxw = err2_t'({1'b0, dist_x_q});
		dyw = err2_t'({1'b0, dist_y_q});
		move_x = e2 > -dyw;
		move_y = e2 < dxw;
		err_sum = err2_t'(err_q) - (move_x ? dyw : '0) + (move_y ? dxw : '0);
		nx = move_x ? cur_x_q + (step_x_neg_q ? '1 : coord_t'(1)) : cur_x_q;
		ny = move_y ? cur_y_q + (step_y_neg_q ? '1 : coord_t'(1)) : cur_y_q;
		done = (nx == target_x_q) && (ny == target_y_q);
		emit = take && (req.kind == REQ_PIXEL) && active_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			target_x_q   <= '0;
			target_y_q   <= '0;
			dist_x_q     <= '0;
			dist_y_q     <= '0;
			step_x_neg_q <= 1'b0;
			step_y_neg_q <= 1'b0;
			err_q        <= '0;
			active_q     <= 1'b0;
		end else if (take && req.kind == REQ_LOAD) begin
			cur_x_q      <= sx;
			cur_y_q      <= sy;
			target_x_q   <= ex;
			target_y_q   <= ey;
			dist_x_q     <= ld_dx;
			dist_y_q     <= ld_dy;
			step_x_neg_q <= !(sx < ex);
			step_y_neg_q <= !(sy < ey);
			err_q        <= err_t'({1'b0, ld_dx}) - err_t'({1'b0, ld_dy});
			active_q     <= (sx != ex) || (sy != ey);
		end else if (emit) begin
			cur_x_q  <= nx;
			cur_y_q  <= ny;
			err_q    <= err_t'(err_sum);
			active_q <= !done;
		end
	end

	assign stat.emit   = emit;
	assign stat.active = active_q;
	assign pix.x       = cur_x_q;
	assign pix.y       = cur_y_q;
	assign pix.last    = done;

endmodule

// File: hw/rtl/line_pixel_generator_core.sv
// Bresenham line rasterizer with a pull interface. A load item (req_type 0)
// takes signed start and end points and replaces any line in progress; it
// gives no result. Each pixel request (req_type 1) while a line is active
// gives one pixel: its coordinates, an in-screen flag, the framebuffer byte
// offset (row * line_bytes + x * (bits_per_pixel / 8), 0 when off-screen)
// and a last mark on the pixel just before the end point, which itself is
// never drawn. A pixel request with no active line is taken and dropped, and
// a line whose start equals its end draws nothing. Rate: one item per clock
// while the output is not stalled; a result passes the pixel register and
// then the output register. The error update and coordinate step are
// formed combinationally at accept time; the offset multiply sits between the
// pixel register and the output register. in_ready drops only while both the
// pixel register and the output register hold results that the consumer has
// not taken, and it follows out_ready combinationally. Write configuration
// only while no pixel is in flight.
module line_pixel_generator_core import lpg_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// request channel
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   req_type,
	input  logic signed [FIELD_W-1:0] start_x,
	input  logic signed [FIELD_W-1:0] start_y,
	input  logic signed [FIELD_W-1:0] end_x,
	input  logic signed [FIELD_W-1:0] end_y,
	// pixel channel
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [FIELD_W-1:0] pix_x,
	output logic signed [FIELD_W-1:0] pix_y,
	output logic                   in_screen,
	output logic [OFS_W-1:0]       byte_offset,
	output logic                   last
);

	logic [SCREEN_W-1:0] screen_width_q;
	logic [SCREEN_W-1:0] screen_height_q;
	logic [LBYTES_W-1:0] line_bytes_q;
	logic [BPP_W-1:0]    bits_per_pixel_q;

	logic       in_fire;
	logic       en_s1, en_s2;
	req_t       req;
	step_stat_t stat;
	pix_t       pix;

	logic       valid_s1;
	pix_t       pix_s1;

	logic       valid_s2;
	coord_t     x_s2, y_s2;
	logic       on_s2;
	logic [OFS_W-1:0] ofs_s2;
	logic       last_s2;

	logic [CMP_W-1:0]     x_ext, y_ext;
	logic                 on;
	logic [SCREEN_W-1:0]  row, col;
	logic [2:0]           byte_step;
	logic [OFS_W-1:0]     row_ofs;
	logic [COL_OFS_W-1:0] col_ofs;
	logic [OFS_W-1:0]     ofs;

	// Configuration registers; the data is cut to each register's width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q   <= RST_SCREEN_WIDTH;
			screen_height_q  <= RST_SCREEN_HEIGHT;
			line_bytes_q     <= RST_LINE_BYTES;
			bits_per_pixel_q <= RST_BITS_PER_PIXEL;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_SCREEN_WIDTH:   screen_width_q   <= cfg_data[SCREEN_W-1:0];
				CFG_SCREEN_HEIGHT:  screen_height_q  <= cfg_data[SCREEN_W-1:0];
				CFG_LINE_BYTES:     line_bytes_q     <= cfg_data[LBYTES_W-1:0];
				CFG_BITS_PER_PIXEL: bits_per_pixel_q <= cfg_data[BPP_W-1:0];
				default: ;
			endcase
		end
	end

	// Stall chain: a stage advances when the one after it is empty or moving.
	assign en_s2    = !valid_s2 || out_ready;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;
	assign in_fire  = in_valid && in_ready;

	assign req.kind    = req_type_t'(req_type);
	assign req.start_x = start_x;
	assign req.start_y = start_y;
	assign req.end_x   = end_x;
	assign req.end_y   = end_y;

	lpg_stepper u_stepper (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (in_fire),
		.req    (req),
		.stat   (stat),
		.pix    (pix)
	);

	// Pixel register: holds the emitted pixel ahead of the address math.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= stat.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && stat.emit) begin
			pix_s1 <= pix;
		end
	end

	// Screen test and byte offset. An on-screen row or column is below a
	// 15-bit limit, so the low bits carry the whole value.
	always_comb begin
		x_ext     = CMP_W'(pix_s1.x);
		y_ext     = CMP_W'(pix_s1.y);
		on        = !pix_s1.x[COORD_BITS-1] && !pix_s1.y[COORD_BITS-1] &&
		            (x_ext < CMP_W'(screen_width_q)) &&
		            (y_ext < CMP_W'(screen_height_q));
		row       = y_ext[SCREEN_W-1:0];
		col       = x_ext[SCREEN_W-1:0];
		byte_step = bits_per_pixel_q[BPP_W-1:3];
		row_ofs   = OFS_W'(row) * OFS_W'(line_bytes_q);
		col_ofs   = COL_OFS_W'(col) * COL_OFS_W'(byte_step);
		ofs       = on ? row_ofs + OFS_W'(col_ofs) : '0;
	end

	// Output register: hold the result until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			x_s2    <= pix_s1.x;
			y_s2    <= pix_s1.y;
			on_s2   <= on;
			ofs_s2  <= ofs;
			last_s2 <= pix_s1.last;
		end
	end

	assign out_valid   = valid_s2;
	assign pix_x       = FIELD_W'(x_s2);
	assign pix_y       = FIELD_W'(y_s2);
	assign in_screen   = on_s2;
	assign byte_offset = ofs_s2;
	assign last        = last_s2;

	// A pixel is only produced from an active line, and the last one ends it.
	a_emit_needs_line: assert property (@(posedge clk) disable iff (!arst_n)
		stat.emit |-> stat.active)
		else $error("pixel emitted with no active line");

	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.emit && pix.last) |=> !stat.active)
		else $error("line still active after its last pixel");

	a_offscreen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !in_screen) |-> (byte_offset == '0))
		else $error("off-screen pixel carries a nonzero offset");

	a_load_no_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && req_type == REQ_LOAD && en_s1) |=> !valid_s1)
		else $error("load transfer produced a pixel");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import lpg_pkg::*;

	// Run length and limits. A pixel passes the pixel register and then the
	// output register before it leaves the block; pad generously around that
	// before config writes and at the end of the run.
	localparam int ITEMS_TARGET  = 950;
	localparam int NUM_PHASES    = 6;
	localparam int PHASE_ITEMS   = 155;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 12;
	localparam int LIMIT_CYCLES  = 250000;
	localparam int MAX_REPORTS   = 60;

	// One expected pixel; has is clear when the request yields nothing.
	typedef struct {
		logic                has;
		logic [FIELD_W-1:0]  x;
		logic [FIELD_W-1:0]  y;
		logic                on;
		logic [OFS_W-1:0]    ofs;
		logic                last;
	} raster_pixel_t;

	// One row of the directed table. Rows with typed set carry their answer;
	// the rest are checked against the line stepper below.
	typedef struct {
		req_type_t           kind;
		logic [FIELD_W-1:0]  sx;
		logic [FIELD_W-1:0]  sy;
		logic [FIELD_W-1:0]  ex;
		logic [FIELD_W-1:0]  ey;
		bit                  typed;
		raster_pixel_t       want;
	} stim_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic                   req_type = REQ_LOAD;
	logic [FIELD_W-1:0]     start_x = '0;
	logic [FIELD_W-1:0]     start_y = '0;
	logic [FIELD_W-1:0]     end_x = '0;
	logic [FIELD_W-1:0]     end_y = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [FIELD_W-1:0]     pix_x;
	logic [FIELD_W-1:0]     pix_y;
	logic                   in_screen;
	logic [OFS_W-1:0]       byte_offset;
	logic                   last;

	line_pixel_generator_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pix_x       (pix_x),
		.pix_y       (pix_y),
		.in_screen   (in_screen),
		.byte_offset (byte_offset),
		.last        (last)
	);

	always #5 clk = ~clk;

	// Shadow copy of the stepper state and of the config registers.
	coord_t        pos_x, pos_y, tgt_x, tgt_y;
	int            dist_x, dist_y, err_acc;
	bit            neg_x, neg_y, line_on;
	logic [SCREEN_W-1:0] cfg_width  = RST_SCREEN_WIDTH;
	logic [SCREEN_W-1:0] cfg_height = RST_SCREEN_HEIGHT;
	logic [LBYTES_W-1:0] cfg_line_bytes = RST_LINE_BYTES;
	logic [BPP_W-1:0]    cfg_bpp = RST_BITS_PER_PIXEL;

	raster_pixel_t pending_pixels[$];
	stim_row_t     stim_rows[$];
	raster_pixel_t no_pixel = '{default: '0};
	int            fail_count = 0;
	int            cycle_count = 0;
	int            burst_left = 0;
	int            rx_cycle = 0;
	int            rx_mode = 0;
	int            rx_stall = 0;

	initial begin
		pos_x = '0; pos_y = '0; tgt_x = '0; tgt_y = '0;
		dist_x = 0; dist_y = 0; err_acc = 0;
		neg_x = 0; neg_y = 0; line_on = 0;
	end

	// Line stepper: a load sets up distances, directions and the error term;
	// a pixel request emits the current point, then steps it by the two-test
	// rule on the doubled error taken before the step.
	function automatic raster_pixel_t rasterize_item(input req_type_t kind,
			input logic [FIELD_W-1:0] sx, sy, ex, ey);
		raster_pixel_t res;
		coord_t        a_x, a_y, b_x, b_y;
		int            px, py, e2;
		longint        ofs;
		res = '{default: '0};
		if (kind == REQ_LOAD) begin
			a_x = coord_t'($signed(sx));
			a_y = coord_t'($signed(sy));
			b_x = coord_t'($signed(ex));
			b_y = coord_t'($signed(ey));
			pos_x = a_x;
			pos_y = a_y;
			tgt_x = b_x;
			tgt_y = b_y;
			dist_x = (b_x > a_x) ? int'(b_x) - int'(a_x) : int'(a_x) - int'(b_x);
			dist_y = (b_y > a_y) ? int'(b_y) - int'(a_y) : int'(a_y) - int'(b_y);
			// Equal coordinates count as a negative step; distance 0 hides it.
			neg_x = !(a_x < b_x);
			neg_y = !(a_y < b_y);
			err_acc = dist_x - dist_y;
			line_on = (a_x != b_x) || (a_y != b_y);
			return res;
		end
		// Requests with no line loaded are dropped silently.
		if (!line_on)
			return res;
		px = int'(pos_x);
		py = int'(pos_y);
		res.has = 1'b1;
		res.x = FIELD_W'(px);
		res.y = FIELD_W'(py);
		res.on = (px >= 0) && (py >= 0) && (px < int'(cfg_width)) && (py < int'(cfg_height));
		if (res.on) begin
			ofs = longint'(py) * longint'(cfg_line_bytes) + longint'(px) * longint'(cfg_bpp >> 3);
			res.ofs = OFS_W'(ofs);
		end
		e2 = 2 * err_acc;
		if (e2 > -dist_y) begin
			err_acc -= dist_y;
			pos_x = coord_t'(px + (neg_x ? -1 : 1));
		end
		if (e2 < dist_x) begin
			err_acc += dist_x;
			pos_y = coord_t'(py + (neg_y ? -1 : 1));
		end
		// Reaching the end point marks this pixel last; the end is never drawn.
		res.last = (pos_x == tgt_x) && (pos_y == tgt_y);
		if (res.last)
			line_on = 0;
		return res;
	endfunction

	function automatic void add_row(input req_type_t kind, input int sx, sy, ex, ey);
		stim_row_t r;
		r.kind = kind;
		r.sx = FIELD_W'(sx);
		r.sy = FIELD_W'(sy);
		r.ex = FIELD_W'(ex);
		r.ey = FIELD_W'(ey);
		r.typed = 0;
		r.want = no_pixel;
		stim_rows.push_back(r);
	endfunction

	function automatic void add_typed(input req_type_t kind, input int sx, sy, ex, ey,
			input bit has, input int px, py, input bit on, input longint ofs, input bit lst);
		add_row(kind, sx, sy, ex, ey);
		stim_rows[$].typed = 1;
		stim_rows[$].want = '{has, FIELD_W'(px), FIELD_W'(py), on, OFS_W'(ofs), lst};
	endfunction

	// Present one request and hold it until it transfers. Bursts of random
	// length alternate with random gaps; valid drops only in a gap.
	task automatic push_request(input req_type_t kind, input logic [FIELD_W-1:0] sx, sy, ex, ey,
			input bit typed, input raster_pixel_t want, output bit counted);
		raster_pixel_t got;
		int            gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		req_type <= kind;
		start_x <= sx;
		start_y <= sy;
		end_x <= ex;
		end_y <= ey;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		got = rasterize_item(kind, sx, sy, ex, ey);
		if (typed) begin
			if (want.has)
				pending_pixels.push_back(want);
		end else if (got.has) begin
			pending_pixels.push_back(got);
		end
		counted = (kind == REQ_LOAD) || got.has;
	endtask

	// Hold off the sender until every expected pixel has come out.
	task automatic drain_pixels();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_pixels.size() != 0)
			@(posedge clk);
	endtask

	// Write all four registers on an idle block, one per cycle.
	task automatic apply_config(input int w, h, lb, bpp);
		drain_pixels();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SCREEN_WIDTH;
		cfg_data <= CFG_DATA_W'(w);
		@(posedge clk);
		cfg_index <= CFG_SCREEN_HEIGHT;
		cfg_data <= CFG_DATA_W'(h);
		@(posedge clk);
		cfg_index <= CFG_LINE_BYTES;
		cfg_data <= CFG_DATA_W'(lb);
		@(posedge clk);
		cfg_index <= CFG_BITS_PER_PIXEL;
		cfg_data <= CFG_DATA_W'(bpp);
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_width = SCREEN_W'(w);
		cfg_height = SCREEN_W'(h);
		cfg_line_bytes = LBYTES_W'(lb);
		cfg_bpp = BPP_W'(bpp);
		@(posedge clk);
	endtask

	// One random line: a load, then mostly as many pixel requests as the line
	// has pixels, with a few extras that fall on an idle stepper. Some lines
	// are cut short and replaced by the next load.
	task automatic run_line_sequence(inout int done_items);
		int sx, sy, ex, ey, mode, len, dy, npix, k;
		bit counted;
		mode = $urandom_range(0, 99);
		if (mode < 70) begin
			sx = $urandom_range(0, 120) - 10;
			sy = $urandom_range(0, 120) - 10;
			ex = sx + $urandom_range(0, 24) - 12;
			ey = sy + $urandom_range(0, 24) - 12;
		end else if (mode < 80) begin
			sx = 32767 - $urandom_range(0, 40);
			sy = 32767 - $urandom_range(0, 40);
			ex = sx - $urandom_range(0, 12);
			ey = sy - $urandom_range(0, 12);
		end else if (mode < 90) begin
			sx = $urandom_range(0, 65535) - 32768;
			sy = $urandom_range(0, 65535) - 32768;
			ex = $urandom_range(0, 65535) - 32768;
			ey = $urandom_range(0, 65535) - 32768;
		end else if (mode < 95) begin
			sx = $urandom_range(0, 120) - 10;
			sy = $urandom_range(0, 120) - 10;
			ex = sx;
			ey = sy;
		end else begin
			sx = -32768 + $urandom_range(0, 20);
			sy = -32768 + $urandom_range(0, 20);
			ex = sx + $urandom_range(0, 12);
			ey = sy + $urandom_range(0, 12);
		end
		// Occasional stray pixel request ahead of the load.
		if ($urandom_range(0, 15) == 0) begin
			push_request(REQ_PIXEL, FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
				FIELD_W'($urandom), 0, no_pixel, counted);
			done_items += counted;
		end
		push_request(REQ_LOAD, FIELD_W'(sx), FIELD_W'(sy), FIELD_W'(ex), FIELD_W'(ey),
			0, no_pixel, counted);
		done_items += counted;
		len = (ex > sx) ? ex - sx : sx - ex;
		dy = (ey > sy) ? ey - sy : sy - ey;
		if (dy > len)
			len = dy;
		if (len > 40)
			npix = $urandom_range(1, 30);
		else if ($urandom_range(0, 99) < 85)
			npix = len + $urandom_range(0, 2);
		else
			npix = $urandom_range(0, len);
		for (k = 0; k < npix; k++) begin
			push_request(REQ_PIXEL, FIELD_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
				FIELD_W'($urandom), 0, no_pixel, counted);
			done_items += counted;
		end
	endtask

	task automatic report_field(input string name, input logic [OFS_W-1:0] want, got);
		if (want !== got) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("time %0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
		end
	endtask

	// Receiver: stall on a pattern that switches at random between
	// always ready, a fixed cadence, random drops and long stall runs.
	always @(posedge clk) begin
		rx_cycle++;
		if (rx_cycle % 150 == 0)
			rx_mode = $urandom_range(0, 3);
		case (rx_mode)
			0: begin
				out_ready <= 1'b1;
			end
			1: begin
				out_ready <= (rx_cycle % 5 != 0) && (rx_cycle % 7 != 3);
			end
			2: begin
				out_ready <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				if (rx_stall > 0) begin
					rx_stall--;
					out_ready <= 1'b0;
				end else if ($urandom_range(0, 15) == 0) begin
					rx_stall = $urandom_range(1, 20);
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
				end
			end
		endcase
	end

	// Check every pixel transfer against the oldest expectation.
	always @(posedge clk) begin : pixel_check
		raster_pixel_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("time %0t: unexpected pixel: expected none, actual x %h y %h",
						$time, pix_x, pix_y);
			end else begin
				want = pending_pixels.pop_front();
				report_field("pix_x", OFS_W'(want.x), OFS_W'(pix_x));
				report_field("pix_y", OFS_W'(want.y), OFS_W'(pix_y));
				report_field("in_screen", OFS_W'(want.on), OFS_W'(in_screen));
				report_field("byte_offset", want.ofs, byte_offset);
				report_field("last", OFS_W'(want.last), OFS_W'(last));
			end
		end
	end

	// Watchdog: end the run if it overruns the cycle budget.
	initial begin : watchdog
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		int  phase, items, total;
		bit  counted, mid_drain;
		// Directed table, run on the reset config (1920 x 1080, 7680, 32 bpp).
		add_typed(REQ_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);             // no line yet
		add_typed(REQ_LOAD, 0, 0, 3, 0, 0, 0, 0, 0, 0, 0);              // flat, y equal
		add_typed(REQ_PIXEL, 0, 0, 0, 0, 1, 0, 0, 1, 0, 0);
		add_typed(REQ_PIXEL, 0, 0, 0, 0, 1, 1, 0, 1, 4, 0);
		add_typed(REQ_PIXEL, 0, 0, 0, 0, 1, 2, 0, 1, 8, 1);
		add_typed(REQ_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);             // line finished
		add_typed(REQ_LOAD, 5, 5, 5, 5, 0, 0, 0, 0, 0, 0);              // start equals end
		add_typed(REQ_PIXEL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_typed(REQ_LOAD, 1919, 1079, 1921, 1081, 0, 0, 0, 0, 0, 0);  // screen corner
		add_typed(REQ_PIXEL, 0, 0, 0, 0, 1, 1919, 1079, 1, 8294396, 0);
		add_typed(REQ_PIXEL, 0, 0, 0, 0, 1, 1920, 1080, 0, 0, 1);
		add_typed(REQ_LOAD, -32768, -32768, 32767, 32767, 0, 0, 0, 0, 0, 0);
		add_typed(REQ_PIXEL, 0, 0, 0, 0, 1, -32768, -32768, 0, 0, 0);
		add_row(REQ_PIXEL, 0, 0, 0, 0);
		add_typed(REQ_LOAD, 32767, 32767, -32768, -32768, 0, 0, 0, 0, 0, 0); // mid-line
		add_typed(REQ_PIXEL, 0, 0, 0, 0, 1, 32767, 32767, 0, 0, 0);
		add_row(REQ_PIXEL, 0, 0, 0, 0);
		add_row(REQ_LOAD, 4, 2, 3, -3);                                  // steep, both negative
		repeat (6)
			add_row(REQ_PIXEL, -1, -1, -1, -1);
		add_typed(REQ_LOAD, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0);             // left of screen
		add_typed(REQ_PIXEL, 0, 0, 0, 0, 1, -1, 0, 0, 0, 1);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		total = 0;
		foreach (stim_rows[i]) begin
			push_request(stim_rows[i].kind, stim_rows[i].sx, stim_rows[i].sy, stim_rows[i].ex,
				stim_rows[i].ey, stim_rows[i].typed, stim_rows[i].want, counted);
			total += counted;
		end

		// Random phases, each on its own register setting: both extremes first.
		for (phase = 0; phase < NUM_PHASES && total < ITEMS_TARGET; phase++) begin
			case (phase)
				0: apply_config(1, 1, 0, 8);
				1: apply_config(32767, 32767, 262143, 32);
				default: apply_config(
					($urandom_range(0, 1) != 0) ? $urandom_range(1, 100) : $urandom_range(1, 32767),
					($urandom_range(0, 1) != 0) ? $urandom_range(1, 100) : $urandom_range(1, 32767),
					$urandom_range(0, 262143), $urandom_range(8, 32));
			endcase
			items = 0;
			mid_drain = 0;
			while (items < PHASE_ITEMS) begin
				// Pause the sender once per phase until the pipe is empty.
				if (!mid_drain && items >= PHASE_ITEMS / 2) begin
					drain_pixels();
					mid_drain = 1;
				end
				run_line_sequence(items);
			end
			total += items;
		end

		drain_pixels();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_pixels.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
